>>> hdl/oaht_pkg.sv
// Shared types and constants for the open-address hash table.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

  localparam int KeyW   = 64;
  localparam int ValW   = 32;
  localparam int SizeW  = 7;
  localparam int SlotW  = 6;
  localparam int StatW  = 3;
  localparam int SumW   = 11;
  localparam int Slots  = 64;
  localparam logic [SizeW-1:0] TableSizeReset = SizeW'(64);

  typedef enum logic [StatW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    sum_load;
    logic    mod_step;
    logic    probe_init;
    logic    probe_next;
    logic    insert;
    logic    res_set;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic is_lookup;
    logic ent_valid;
    logic key_hit;
    logic probe_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/oaht_in_if.sv
// Request channel of the hash table: operation, key and value.
// Depends on oaht_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oaht_in_if;
  import oaht_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [KeyW-1:0] key;
  logic [ValW-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink (input valid, input kind, input key, input value, output ready);
endinterface

`default_nettype wire

>>> hdl/oaht_out_if.sv
// Response channel of the hash table: status, slot and stored value.
// Depends on oaht_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface oaht_out_if;
  import oaht_pkg::*;

  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [SlotW-1:0] slot;
  logic [ValW-1:0]  value_out;

  modport source (output valid, output status, output slot, output value_out, input ready);
  modport sink (input valid, input status, input slot, input value_out, output ready);
endinterface

`default_nettype wire

>>> hdl/oaht_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/oaht_ctrl.sv
// Controller of the hash table: sequences clearing, hashing, probing and the reply.
// Depends on oaht_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module oaht_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire oaht_pkg::sts_t sts_i,
  output oaht_pkg::cmd_t     cmd_o
);
  import oaht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_MOD,
    S_INIT,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_d      = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd.probe_init = 1'b1;
        state_d        = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.ent_valid) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts_i.is_lookup ? ST_NOT_FOUND : ST_INSERTED;
          cmd.insert   = !sts_i.is_lookup;
          state_d      = S_RESULT;
        end else if (sts_i.key_hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts_i.is_lookup ? ST_FOUND : ST_PRESENT;
          state_d      = S_RESULT;
        end else if (sts_i.probe_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts_i.is_lookup ? ST_NOT_FOUND : ST_FULL;
          state_d      = S_RESULT;
        end else begin
          cmd.probe_next = 1'b1;
          state_d        = S_READ;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

>>> hdl/oaht_dpath.sv
// Datapath of the hash table: size register, key capture, byte-sum hash,
// remainder unit, probe stepper, slot memories and the reply register.
// Depends on oaht_pkg and oaht_ram.
`timescale 1ns / 1ps
`default_nettype none

module oaht_dpath #(
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [oaht_pkg::SizeW-1:0]    cfg_data_i,
  input  wire logic                          kind_i,
  input  wire logic [oaht_pkg::KeyW-1:0]     key_i,
  input  wire logic [oaht_pkg::ValW-1:0]     value_i,
  input  wire oaht_pkg::cmd_t                cmd_i,
  output oaht_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [oaht_pkg::StatW-1:0]         status_o,
  output logic [oaht_pkg::SlotW-1:0]         slot_o,
  output logic [oaht_pkg::ValW-1:0]          value_out_o
);
  import oaht_pkg::*;

  localparam int IdxW   = $clog2(Slots);
  localparam int StoreW = (VALUE_BITS < ValW) ? VALUE_BITS : ValW;
  localparam int CntW   = $clog2(SumW);

  function automatic logic [KeyW-1:0] normalize_key(input logic [KeyW-1:0] k);
    logic [KeyW-1:0] res;
    logic            alive;
    res   = '0;
    alive = 1'b1;
    for (int b = 0; b < KeyW / 8; b++) begin
      if (b >= KEY_BYTES || k[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        res[8*b +: 8] = k[8*b +: 8];
      end
    end
    return res;
  endfunction

  function automatic logic [SumW-1:0] byte_sum(input logic [KeyW-1:0] k);
    logic [SumW-1:0] s;
    s = '0;
    for (int b = 0; b < KeyW / 8; b++) begin
      s = s + SumW'(k[8*b +: 8]);
    end
    return s;
  endfunction

  logic [SizeW-1:0]  table_size_q;
  logic [SizeW-1:0]  size_q, size_in_use;
  logic              lookup_q;
  logic [KeyW-1:0]   key_q;
  logic [StoreW-1:0] value_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   cnt_q;
  logic [SizeW-1:0]  rem_q;
  logic [SizeW:0]    rem_shift, rem_sub;
  logic [SizeW-1:0]  pos_q, step_q, j_q;
  logic [SizeW:0]    pos_sum, step_sum;
  logic [IdxW-1:0]   clr_q;
  logic [IdxW-1:0]   ram_addr;
  logic              valid_we, valid_wdata, valid_rdata;
  logic              kv_we;
  logic [KeyW+StoreW-1:0] kv_rdata;
  logic [StatW-1:0]  res_status_q;
  logic [SlotW-1:0]  res_slot_q;
  logic [ValW-1:0]   res_value_q;
  logic              out_valid_q;
  logic [StatW-1:0]  out_status_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [ValW-1:0]   out_value_q;
  logic              slot_hit;

  always_comb begin
    if (table_size_q == '0) begin
      size_in_use = SizeW'(1);
    end else if (int'(table_size_q) > Slots) begin
      size_in_use = SizeW'(Slots);
    end else begin
      size_in_use = table_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableSizeReset;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        table_size_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rem_shift = {rem_q, sum_q[cnt_q]};
  assign rem_sub   = rem_shift - {1'b0, size_q};
  assign pos_sum   = {1'b0, pos_q} + {1'b0, step_q};
  assign step_sum  = {1'b0, step_q} + (SizeW + 1)'(2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q   <= size_in_use;
      lookup_q <= (kind_i == OP_LOOKUP);
      key_q    <= normalize_key(key_i);
      value_q  <= value_i[StoreW-1:0];
    end
    if (cmd_i.sum_load) begin
      sum_q <= byte_sum(key_q);
      cnt_q <= CntW'(SumW - 1);
      rem_q <= '0;
    end
    if (cmd_i.mod_step) begin
      cnt_q <= cnt_q - CntW'(1);
      rem_q <= (rem_shift >= {1'b0, size_q}) ? rem_sub[SizeW-1:0] : rem_shift[SizeW-1:0];
    end
    if (cmd_i.probe_init) begin
      pos_q  <= rem_q;
      step_q <= (size_q == SizeW'(1)) ? '0 : SizeW'(1);
      j_q    <= '0;
    end
    if (cmd_i.probe_next) begin
      j_q    <= j_q + SizeW'(1);
      pos_q  <= (pos_sum >= {1'b0, size_q}) ? SizeW'(pos_sum - {1'b0, size_q})
                                            : pos_sum[SizeW-1:0];
      step_q <= (step_sum >= {1'b0, size_q}) ? SizeW'(step_sum - {1'b0, size_q})
                                             : step_sum[SizeW-1:0];
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_code;
      res_slot_q   <= slot_hit ? SlotW'(pos_q) : '0;
      res_value_q  <= (cmd_i.res_code == ST_FOUND) ? ValW'(kv_rdata[StoreW-1:0]) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_value_q  <= res_value_q;
    end
  end

  assign slot_hit = (cmd_i.res_code == ST_INSERTED) || (cmd_i.res_code == ST_PRESENT) ||
                    (cmd_i.res_code == ST_FOUND);

  assign ram_addr    = cmd_i.clear ? clr_q : IdxW'(pos_q);
  assign valid_we    = cmd_i.clear || cmd_i.insert;
  assign valid_wdata = !cmd_i.clear;
  assign kv_we       = cmd_i.insert;

  oaht_ram #(
    .WIDTH (1),
    .DEPTH (Slots)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (valid_we),
    .addr_i  (ram_addr),
    .wdata_i (valid_wdata),
    .rdata_o (valid_rdata)
  );

  oaht_ram #(
    .WIDTH (KeyW + StoreW),
    .DEPTH (Slots)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .addr_i  (ram_addr),
    .wdata_i ({key_q, value_q}),
    .rdata_o (kv_rdata)
  );

  assign sts_o.clear_last = (clr_q == IdxW'(Slots - 1));
  assign sts_o.mod_last   = (cnt_q == '0);
  assign sts_o.is_lookup  = lookup_q;
  assign sts_o.ent_valid  = valid_rdata;
  assign sts_o.key_hit    = (kv_rdata[KeyW+StoreW-1:StoreW] == key_q);
  assign sts_o.probe_last = (j_q == size_q - SizeW'(1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign value_out_o = out_value_q;

endmodule

`default_nettype wire

>>> hdl/open_address_hash_table.sv
// Top level of the open-address hash table with quadratic probing.
// Depends on oaht_pkg, oaht_in_if, oaht_out_if, oaht_ctrl and oaht_dpath.
//
// Each request word on req_i is an insert or a lookup with a key of up to
// eight bytes; each one yields exactly one response word on rsp_o with a
// status, a slot and, for a hit on lookup, the stored value.
// The cfg_we_i/cfg_data_i port writes the table size, which resets to 64.
// One request is in work at a time. After acceptance a request steps
// through forming the byte sum, the bit-serial remainder over the eleven
// bits of that sum, starting the probe, then for each probe (1 to the
// table size) a registered read of the slot memory followed by the
// compare, and finally loading the response register. The next request
// is accepted once the response register is loaded.
// After reset the valid memory is cleared one slot a cycle over all 64
// slots, during which no request is accepted.
// The response register holds its word while rsp_o is stalled; the next
// request is still accepted and processed, and waits only for that
// register before its own response is loaded.
`timescale 1ns / 1ps
`default_nettype none

module open_address_hash_table #(
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [oaht_pkg::SizeW-1:0] cfg_data_i,
  oaht_in_if.sink                         req_i,
  oaht_out_if.source                      rsp_o
);
  import oaht_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  oaht_dpath #(
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (req_i.kind),
    .key_i       (req_i.key),
    .value_i     (req_i.value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .slot_o      (rsp_o.slot),
    .value_out_o (rsp_o.value_out)
  );

  assign req_i.ready = req_ready;

  a_insert_empty_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !sts.ent_valid)
    else $error("insert written over an occupied slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(rsp_o.valid && !rsp_o.ready))
    else $error("response word overwritten while stalled");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.probe_next |-> !sts.probe_last)
    else $error("probe sequence ran past the table size");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request accepted while one is in work");

endmodule

`default_nettype wire
